// File: rtl/plc_pkg.sv
// Shared constants for the padded length calculator.
// Holds field widths, register indexes and reset values; depends on nothing.
package plc_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 60;
  localparam int unsigned OUT_W           = 62;
  localparam int unsigned OUT_DATA_W      = 64;
  localparam int unsigned STEP_W          = 32;
  localparam int unsigned MINPAD_W        = 16;
  localparam int unsigned CFG_W           = 32;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PADDING = 2'd2;

  localparam logic [STEP_W-1:0]   PAD_STEP_RST    = 32'd1;
  localparam logic [MINPAD_W-1:0] MIN_PADDING_RST = 16'd10;

endpackage

// File: rtl/plc_rem_pipe.sv
// Pipelined restoring remainder unit: one bit of the length per stage.
// Produces length modulo step, registered at the last stage; uses plc_pkg.
module plc_rem_pipe #(
  parameter int unsigned LENGTH_BITS = plc_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [LENGTH_BITS-1:0]      len_i,
  input  logic [plc_pkg::STEP_W-1:0]  step_i,
  output logic                        vld_o,
  output logic [LENGTH_BITS-1:0]      len_o,
  output logic [plc_pkg::STEP_W-1:0]  rem_o
);

  localparam int unsigned StepW = plc_pkg::STEP_W;

  logic                   vld_q [LENGTH_BITS+1];
  logic [LENGTH_BITS-1:0] len_q [LENGTH_BITS+1];
  logic [StepW-1:0]       rem_q [LENGTH_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q[0] <= len_i;
      rem_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < LENGTH_BITS; k++) begin : g_stage
    logic [StepW:0] trial;
    logic [StepW:0] diff;
    logic [StepW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k], len_q[k][LENGTH_BITS-1-k]};
      diff  = trial - {1'b0, step_i};
      rem_d = (trial >= {1'b0, step_i}) ? diff[StepW-1:0] : trial[StepW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k+1] <= len_q[k];
        rem_q[k+1] <= rem_d;
      end
    end
  end

  assign vld_o = vld_q[LENGTH_BITS];
  assign len_o = len_q[LENGTH_BITS];
  assign rem_o = rem_q[LENGTH_BITS];

endmodule

// File: rtl/padded_length_calculator_unit.sv
// Top level of the padded length calculator: remainder pipeline plus finishing stages.
// Depends on plc_pkg and plc_rem_pipe.
//
// Usage: a plaintext length enters on the slave stream (s_axis_*), and the
// padded length, including the marker byte, leaves on the master stream
// (m_axis_*). Every accepted transaction gives exactly one result transaction.
// The configuration port writes use_step, padding_step and minimal_padding;
// it must be written only while no transaction is in flight, a user rule that
// the block does not enforce. The pipeline has one input stage, one remainder stage
// per length bit, a leading-one stage, a rounding stage and the output register,
// and takes one transaction per cycle unless the receiver stalls; the bit-serial
// remainder pipeline sets the depth and the single compare-subtract per stage
// sets the clock. Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds, and s_axis_tready_o drops
// only while a result waits and m_axis_tready_i is low; the pipeline stages keep
// every transaction in flight, so nothing is lost or repeated.
module padded_length_calculator_unit #(
  parameter int unsigned LENGTH_BITS = plc_pkg::LENGTH_BITS_DEF,
  localparam int unsigned InDataW = ((LENGTH_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Bits from the lowest up: clear_size, zero fill.
  input  logic [InDataW-1:0]             s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Bits from the lowest up: padded_size, zero fill.
  output logic [plc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic                           cfg_we_i,
  input  logic [plc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plc_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned StepW   = plc_pkg::STEP_W;
  localparam int unsigned MinPadW = plc_pkg::MINPAD_W;
  localparam int unsigned OutW    = plc_pkg::OUT_W;
  localparam int unsigned CalcW   = ((LENGTH_BITS > StepW) ? LENGTH_BITS : StepW) + 2;
  localparam int unsigned EW      = $clog2(LENGTH_BITS);

  logic               use_step_q;
  logic [StepW-1:0]   pad_step_q;
  logic [MinPadW-1:0] min_pad_q;
  logic [StepW-1:0]   step_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_step_q <= 1'b0;
      pad_step_q <= plc_pkg::PAD_STEP_RST;
      min_pad_q  <= plc_pkg::MIN_PADDING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plc_pkg::CFG_USE_STEP:    use_step_q <= cfg_wdata_i[0];
        plc_pkg::CFG_PAD_STEP:    pad_step_q <= cfg_wdata_i[StepW-1:0];
        plc_pkg::CFG_MIN_PADDING: min_pad_q  <= cfg_wdata_i[MinPadW-1:0];
        default: ;
      endcase
    end
  end

  assign step_eff = (pad_step_q == '0) ? StepW'(1) : pad_step_q;

  logic                    en;
  logic                    m_vld_q;
  logic [OutW-1:0]         m_data_q;

  assign en              = !m_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic                   rp_vld;
  logic [LENGTH_BITS-1:0] rp_len;
  logic [StepW-1:0]       rp_rem;

  plc_rem_pipe #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_rem_pipe (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s_axis_tvalid_i),
    .len_i (s_axis_tdata_i[LENGTH_BITS-1:0]),
    .step_i(step_eff),
    .vld_o (rp_vld),
    .len_o (rp_len),
    .rem_o (rp_rem)
  );

  // Leading-one stage.
  logic [EW-1:0]          top_d;
  logic                   f1_vld_q;
  logic [LENGTH_BITS-1:0] f1_len_q;
  logic [StepW-1:0]       f1_rem_q;
  logic [EW-1:0]          f1_top_q;
  logic                   f1_small_q;
  logic                   f1_zero_q;

  always_comb begin
    top_d = '0;
    for (int i = 0; i < LENGTH_BITS; i++) begin
      if (rp_len[i]) begin
        top_d = EW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= rp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_len_q   <= rp_len;
      f1_rem_q   <= rp_rem;
      f1_top_q   <= top_d;
      f1_small_q <= (rp_len[LENGTH_BITS-1:1] == '0);
      f1_zero_q  <= (rp_len == '0);
    end
  end

  // Rounding stage.
  logic [EW-1:0]    exp_top;
  logic [EW-1:0]    shamt;
  logic [CalcW-1:0] mask;
  logic [CalcW-1:0] len_ext;
  logic [CalcW-1:0] padme_d;
  logic [CalcW-1:0] stepped_d;
  logic             f2_vld_q;
  logic [CalcW-1:0] f2_padme_q;
  logic [CalcW-1:0] f2_step_q;

  always_comb begin
    exp_top = '0;
    for (int i = 0; i < EW; i++) begin
      if (f1_top_q[i]) begin
        exp_top = EW'(i);
      end
    end
    shamt   = f1_top_q - exp_top - EW'(1);
    mask    = (CalcW'(1) << shamt) - CalcW'(1);
    len_ext = CalcW'(f1_len_q);
    padme_d = f1_small_q ? '0 : ((len_ext + mask) & ~mask);
    if (f1_zero_q) begin
      stepped_d = CalcW'(step_eff);
    end else if (f1_rem_q == '0) begin
      stepped_d = len_ext;
    end else begin
      stepped_d = len_ext + CalcW'(step_eff - f1_rem_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_padme_q <= padme_d;
      f2_step_q  <= stepped_d;
    end
  end

  // Output stage.
  logic [CalcW-1:0] min_ext;
  logic [CalcW-1:0] sel;
  logic [CalcW-1:0] res;
  logic [OutW-1:0]  m_data_d;

  always_comb begin
    min_ext = CalcW'(min_pad_q);
    if (use_step_q) begin
      sel = f2_step_q;
    end else if (f2_padme_q < min_ext) begin
      sel = min_ext;
    end else begin
      sel = f2_padme_q;
    end
    res      = sel + CalcW'(1);
    m_data_d = OutW'(res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = plc_pkg::OUT_DATA_W'(m_data_q);

endmodule

// File: rtl/plc_checker.sv
// Port-level checks for padded_length_calculator_unit, attached by bind.
// Depends on plc_pkg and the top level's port names.
module plc_checker #(
  parameter int unsigned LENGTH_BITS = plc_pkg::LENGTH_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic [plc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i
);

  localparam int unsigned OutW = plc_pkg::OUT_W;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Result transaction dropped while stalled.");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("Result data changed while stalled.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("Input stalled without output back-pressure.");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (LENGTH_BITS > 60) || (m_axis_tdata_o[OutW-1:0] != '0))
    else $error("Padded size of zero delivered.");

endmodule

bind padded_length_calculator_unit plc_checker #(
  .LENGTH_BITS(LENGTH_BITS)
) u_plc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i)
);
